@@ hw/rtl/wgn_pkg.sv @@
// ----------------------------------------------------------------------------
// wgn_pkg
// Shared widths, defaults and controller/datapath link types for the
// weighted group l1,2 norm block.
// ----------------------------------------------------------------------------
package wgn_pkg;

  localparam int SAMPLE_W_DEF       = 16;
  localparam int GROUP_LEN_LOG2_DEF = 8;
  localparam int WEIGHT_W           = 16;
  localparam int WEIGHT_FRAC        = 8;
  localparam int ROOT_W             = 28;
  localparam int TOTAL_W            = 48;

  typedef struct packed {
    logic capture;
    logic accumulate;
    logic close_group;
    logic root_step;
    logic mul_load;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic root_last;
  } status_t;

endpackage

@@ hw/rtl/wgn_if.sv @@
// ----------------------------------------------------------------------------
// wgn_if
// Valid/ready channel interfaces for coefficient items and result items.
// ----------------------------------------------------------------------------
interface wgn_in_if
  import wgn_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_W_DEF
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] re_part;
  logic signed [SAMPLE_WIDTH-1:0] im_part;
  logic        [WEIGHT_W-1:0]     weight;
  logic                           group_end;
  logic                           set_end;

  modport source (output valid, re_part, im_part, weight, group_end, set_end,
                  input ready);
  modport sink   (input valid, re_part, im_part, weight, group_end, set_end,
                  output ready);
endinterface

interface wgn_out_if
  import wgn_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [ROOT_W-1:0]  weighted_root;
  logic [TOTAL_W-1:0] running_total;
  logic               is_final;

  modport source (output valid, weighted_root, running_total, is_final,
                  input ready);
  modport sink   (input valid, weighted_root, running_total, is_final,
                  output ready);
endinterface

@@ hw/rtl/wgn_dp.sv @@
// ----------------------------------------------------------------------------
// wgn_dp
// Datapath: squares, saturating group accumulator, bit-serial square root,
// weight multiply and saturating running total with output registers.
// ----------------------------------------------------------------------------
module wgn_dp
  import wgn_pkg::*;
#(
  parameter int SAMPLE_WIDTH   = SAMPLE_W_DEF,
  parameter int GROUP_LEN_LOG2 = GROUP_LEN_LOG2_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  cmd_t                           cmd,
  output status_t                        status,
  input  logic signed [SAMPLE_WIDTH-1:0] re_part,
  input  logic signed [SAMPLE_WIDTH-1:0] im_part,
  input  logic        [WEIGHT_W-1:0]     weight,
  input  logic                           set_end,
  output logic        [ROOT_W-1:0]       weighted_root,
  output logic        [TOTAL_W-1:0]      running_total,
  output logic                           is_final
);

  localparam int SQ_W   = 2 * SAMPLE_WIDTH;
  localparam int ACC_W  = SQ_W + GROUP_LEN_LOG2;
  localparam int RT_W   = (ACC_W + 1) / 2;
  localparam int RAD_W  = 2 * RT_W;
  localparam int REM_W  = RT_W + 2;
  localparam int PROD_W = RT_W + WEIGHT_W;
  localparam int SHR_W  = PROD_W - WEIGHT_FRAC;
  localparam int CNT_W  = $clog2(RT_W);
  localparam logic [63:0] ROOT_MAX = (64'd1 << ROOT_W) - 64'd1;

  logic signed [SQ_W-1:0]    re_sq;
  logic signed [SQ_W-1:0]    im_sq;
  logic        [SQ_W-1:0]    sq_re_r;
  logic        [SQ_W-1:0]    sq_im_r;
  logic        [WEIGHT_W-1:0] weight_r;
  logic                      set_end_r;
  logic        [SQ_W:0]      sq_pair;
  logic        [ACC_W:0]     acc_sum;
  logic        [ACC_W-1:0]   acc_sat;
  logic        [ACC_W-1:0]   sum_r;
  logic        [RAD_W-1:0]   rad_r;
  logic        [REM_W-1:0]   rem_r;
  logic        [RT_W-1:0]    root_r;
  logic        [CNT_W-1:0]   cnt_r;
  logic        [REM_W-1:0]   rem_shift;
  logic        [REM_W-1:0]   trial;
  logic                      take;
  logic        [PROD_W-1:0]  prod_r;
  logic        [SHR_W-1:0]   shr;
  logic        [63:0]        shr_ext;
  logic        [ROOT_W-1:0]  wr;
  logic        [TOTAL_W:0]   total_sum;
  logic        [TOTAL_W-1:0] total_sat;
  logic        [TOTAL_W-1:0] total_r;
  logic        [ROOT_W-1:0]  wr_out_r;
  logic        [TOTAL_W-1:0] total_out_r;
  logic                      final_r;

  assign re_sq = SQ_W'(re_part) * SQ_W'(re_part);
  assign im_sq = SQ_W'(im_part) * SQ_W'(im_part);

  assign sq_pair = {1'b0, sq_re_r} + {1'b0, sq_im_r};
  assign acc_sum = {1'b0, sum_r} + (ACC_W + 1)'(sq_pair);
  assign acc_sat = acc_sum[ACC_W] ? {ACC_W{1'b1}} : acc_sum[ACC_W-1:0];

  assign rem_shift = {rem_r[RT_W-1:0], rad_r[RAD_W-1 -: 2]};
  assign trial     = {root_r, 2'b01};
  assign take      = (rem_shift >= trial);

  assign status.root_last = (cnt_r == CNT_W'(RT_W - 1));

  assign shr       = prod_r[PROD_W-1:WEIGHT_FRAC];
  assign shr_ext   = 64'(shr);
  assign wr        = (shr_ext > ROOT_MAX) ? ROOT_MAX[ROOT_W-1:0] : shr_ext[ROOT_W-1:0];
  assign total_sum = {1'b0, total_r} + (TOTAL_W + 1)'(wr);
  assign total_sat = total_sum[TOTAL_W] ? {TOTAL_W{1'b1}} : total_sum[TOTAL_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r   <= '0;
      total_r <= '0;
    end else begin
      if (cmd.close_group) begin
        sum_r <= '0;
      end else if (cmd.accumulate) begin
        sum_r <= acc_sat;
      end
      if (cmd.emit) begin
        total_r <= set_end_r ? '0 : total_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sq_re_r   <= SQ_W'(re_sq);
      sq_im_r   <= SQ_W'(im_sq);
      weight_r  <= weight;
      set_end_r <= set_end;
    end
    if (cmd.close_group) begin
      rad_r  <= RAD_W'(acc_sat);
      rem_r  <= '0;
      root_r <= '0;
      cnt_r  <= '0;
    end else if (cmd.root_step) begin
      rad_r  <= {rad_r[RAD_W-3:0], 2'b00};
      rem_r  <= take ? (rem_shift - trial) : rem_shift;
      root_r <= {root_r[RT_W-2:0], take};
      cnt_r  <= cnt_r + CNT_W'(1);
    end
    if (cmd.mul_load) begin
      prod_r <= PROD_W'(root_r) * PROD_W'(weight_r);
    end
    if (cmd.emit) begin
      wr_out_r    <= wr;
      total_out_r <= total_sat;
      final_r     <= set_end_r;
    end
  end

  assign weighted_root = wr_out_r;
  assign running_total = total_out_r;
  assign is_final      = final_r;

endmodule

@@ hw/rtl/wgn_ctrl.sv @@
// ----------------------------------------------------------------------------
// wgn_ctrl
// Controller: input handshake, group-end sequencing through root, multiply
// and emit, and the output valid register.
// ----------------------------------------------------------------------------
module wgn_ctrl
  import wgn_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  logic    in_group_end,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output cmd_t    cmd,
  input  status_t status
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROOT,
    ST_MUL,
    ST_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   s1_valid_r;
  logic   s1_gend_r;
  logic   pending_r, pending_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;
  logic   out_free;

  assign in_ready  = !pending_r;
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt       = state_r;
    pending_nxt     = pending_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    cmd             = '0;
    cmd.capture     = accept;
    cmd.accumulate  = s1_valid_r;
    cmd.close_group = s1_valid_r && s1_gend_r;
    if (accept && in_group_end) begin
      pending_nxt = 1'b1;
    end
    case (state_r)
      ST_IDLE: begin
        if (cmd.close_group) begin
          state_nxt = ST_ROOT;
        end
      end
      ST_ROOT: begin
        cmd.root_step = 1'b1;
        if (status.root_last) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul_load = 1'b1;
        state_nxt    = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          cmd.emit      = 1'b1;
          out_valid_nxt = 1'b1;
          pending_nxt   = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      s1_valid_r  <= 1'b0;
      s1_gend_r   <= 1'b0;
      pending_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      s1_valid_r  <= accept;
      s1_gend_r   <= accept && in_group_end;
      pending_r   <= pending_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ hw/rtl/weighted_group_l12_norm.sv @@
// ----------------------------------------------------------------------------
// weighted_group_l12_norm
// Fixed-point weighted group l1,2 norm over a stream of complex coefficients.
//
// The in_ch channel carries one coefficient per item: signed real and
// imaginary parts, a Q8.8 weight and the group_end and set_end flags.
// Items without group_end are taken one per cycle while no group end is
// pending; their squared magnitudes are registered, then added into a
// saturating accumulator. An item with group_end closes the group: in_ch.ready
// drops until its result has been written to the out_ch register. The square
// root is computed one bit per cycle over ROOT_BITS result bits (ROOT_BITS =
// (2*SAMPLE_WIDTH + GROUP_LEN_LOG2 + 1) / 2, 20 by default), then the root is
// multiplied by the weight and the result is emitted.
// The out_ch channel carries weighted_root, running_total and is_final; the
// total returns to zero after a group end item that carries set_end.
// If the receiver stalls, the result waits in the output register while new
// coefficients are still taken; only the next group end waits for the slot.
// Synchronous reset clears the accumulator, the total and all control state.
// ----------------------------------------------------------------------------
module weighted_group_l12_norm
  import wgn_pkg::*;
#(
  parameter int SAMPLE_WIDTH   = SAMPLE_W_DEF,
  parameter int GROUP_LEN_LOG2 = GROUP_LEN_LOG2_DEF
) (
  input logic clk,
  input logic rst_n,
  wgn_in_if.sink    in_ch,
  wgn_out_if.source out_ch
);

  cmd_t    cmd;
  status_t status;

  wgn_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_group_end (in_ch.group_end),
    .in_ready     (in_ch.ready),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .cmd          (cmd),
    .status       (status)
  );

  wgn_dp #(
    .SAMPLE_WIDTH   (SAMPLE_WIDTH),
    .GROUP_LEN_LOG2 (GROUP_LEN_LOG2)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .status        (status),
    .re_part       (in_ch.re_part),
    .im_part       (in_ch.im_part),
    .weight        (in_ch.weight),
    .set_end       (in_ch.set_end),
    .weighted_root (out_ch.weighted_root),
    .running_total (out_ch.running_total),
    .is_final      (out_ch.is_final)
  );

endmodule

@@ hw/rtl/wgn_checker.sv @@
// ----------------------------------------------------------------------------
// wgn_checker
// Port-level checks on the norm block's handshakes and result timing.
// ----------------------------------------------------------------------------
module wgn_checker
  import wgn_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               in_group_end,
  input logic               out_valid,
  input logic               out_ready,
  input logic [ROOT_W-1:0]  out_root,
  input logic [TOTAL_W-1:0] out_total,
  input logic               out_final
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_root) &&
    $stable(out_total) && $stable(out_final))
    else $error("Stalled result item changed.");

  a_gend_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_group_end |=> !in_ready)
    else $error("Input still ready after a group end item.");

  a_ready_fall: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_ready) |-> $past(in_valid && in_group_end))
    else $error("Input ready fell without a group end item.");

  a_ready_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_ready) |-> out_valid)
    else $error("Input ready returned without a result item.");

endmodule

bind weighted_group_l12_norm wgn_checker u_wgn_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .in_group_end (in_ch.group_end),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_root     (out_ch.weighted_root),
  .out_total    (out_ch.running_total),
  .out_final    (out_ch.is_final)
);

@@ tb/wgn_norm_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wgn_norm_checker
// Watches the coefficient and result channels of the weighted group l1,2 norm
// block. Every accepted item updates a private model of the square sum; each
// group end updates the running total and queues the result it must produce.
// Each accepted result is compared field by field with the oldest queued one.
// ----------------------------------------------------------------------------
module wgn_norm_checker
  import wgn_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  wgn_in_if           in_mon,
  wgn_out_if          out_mon,
  output int unsigned mismatch_count,
  output int unsigned open_results
);

  localparam int          ACC_W     = 2 * SAMPLE_W_DEF + GROUP_LEN_LOG2_DEF;
  localparam int          ROOT_BITS = (ACC_W + 1) / 2;
  localparam logic [63:0] ACC_MAX   = (64'd1 << ACC_W) - 64'd1;
  localparam logic [63:0] ROOT_MAX  = (64'd1 << ROOT_W) - 64'd1;
  localparam logic [63:0] TOTAL_MAX = (64'd1 << TOTAL_W) - 64'd1;

  typedef struct {
    logic [ROOT_W-1:0]  weighted_root;
    logic [TOTAL_W-1:0] running_total;
    logic               is_final;
  } norm_result_t;

  norm_result_t expected_norms[$];
  logic [63:0]  energy_sum;
  logic [63:0]  norm_sum;
  int unsigned  fail_tally;

  function automatic logic [63:0] squared_mag(input logic signed [SAMPLE_W_DEF-1:0] s);
    longint v;
    v = longint'(s);
    if (v < 0) begin
      v = -v;
    end
    return 64'(v * v);
  endfunction

  function automatic logic [63:0] floor_sqrt(input logic [63:0] n);
    logic [63:0] r;
    logic [63:0] t;
    r = '0;
    for (int b = ROOT_BITS; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= n) begin
        r = t;
      end
    end
    return r;
  endfunction

  task automatic absorb_coefficient();
    logic [63:0]  sq;
    logic [63:0]  wr;
    norm_result_t r;
    sq = squared_mag(in_mon.re_part) + squared_mag(in_mon.im_part);
    if (sq > ACC_MAX || energy_sum > ACC_MAX - sq) begin
      energy_sum = ACC_MAX;
    end else begin
      energy_sum = energy_sum + sq;
    end
    if (in_mon.group_end) begin
      wr = (floor_sqrt(energy_sum) * 64'(in_mon.weight)) >> WEIGHT_FRAC;
      if (wr > ROOT_MAX) begin
        wr = ROOT_MAX;
      end
      if (norm_sum > TOTAL_MAX - wr) begin
        norm_sum = TOTAL_MAX;
      end else begin
        norm_sum = norm_sum + wr;
      end
      r.weighted_root = wr[ROOT_W-1:0];
      r.running_total = norm_sum[TOTAL_W-1:0];
      r.is_final      = in_mon.set_end;
      expected_norms.push_back(r);
      energy_sum = '0;
      if (in_mon.set_end) begin
        norm_sum = '0;
      end
    end
  endtask

  task automatic compare_norm();
    norm_result_t e;
    if (expected_norms.size() == 0) begin
      $display("%0t: result with nothing expected: root=%0d total=%0d final=%0b",
               $time, out_mon.weighted_root, out_mon.running_total, out_mon.is_final);
      fail_tally++;
    end else begin
      e = expected_norms.pop_front();
      if (out_mon.weighted_root !== e.weighted_root) begin
        $display("%0t: weighted_root expected %0d actual %0d",
                 $time, e.weighted_root, out_mon.weighted_root);
        fail_tally++;
      end
      if (out_mon.running_total !== e.running_total) begin
        $display("%0t: running_total expected %0d actual %0d",
                 $time, e.running_total, out_mon.running_total);
        fail_tally++;
      end
      if (out_mon.is_final !== e.is_final) begin
        $display("%0t: is_final expected %0b actual %0b",
                 $time, e.is_final, out_mon.is_final);
        fail_tally++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      energy_sum = '0;
      norm_sum   = '0;
      expected_norms.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        compare_norm();
      end
      if (in_mon.valid && in_mon.ready) begin
        absorb_coefficient();
      end
    end
    mismatch_count <= fail_tally;
    open_results   <= expected_norms.size();
  end

endmodule

@@ tb/tb_weighted_group_l12_norm.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_weighted_group_l12_norm
// Drives coefficient items into the weighted group l1,2 norm block and takes
// its results with random gaps on both sides, burst phases without gaps, one
// long receiver hold and two sender pauses. A directed part covers the sample
// extremes, weight extremes, set ends and one long group of extreme samples;
// random groups follow. The checker beside the block judges each result.
// ----------------------------------------------------------------------------
module tb_weighted_group_l12_norm;
  import wgn_pkg::*;

  localparam int CLK_PERIOD     = 12;
  localparam int RESET_CYCLES   = 12;
  localparam int QUIET_LIMIT    = 2000;
  localparam int LONG_HOLD      = 300;
  localparam int HOLD_AT        = 20;
  localparam int DRAIN_CYCLES   = 30;
  localparam int LONG_GROUP_LEN = 60;

  localparam logic signed [SAMPLE_W_DEF-1:0] S_MIN = {1'b1, {(SAMPLE_W_DEF-1){1'b0}}};
  localparam logic signed [SAMPLE_W_DEF-1:0] S_MAX = ~S_MIN;

  logic        clk;
  logic        rst_n;
  bit          burst_phase;
  bit          long_hold_done;
  int unsigned mismatch_count;
  int unsigned open_results;
  int unsigned results_taken;
  int unsigned items_sent;
  int unsigned quiet_cycles;

  wgn_in_if #(.SAMPLE_WIDTH(SAMPLE_W_DEF)) in_ch ();
  wgn_out_if out_ch ();

  weighted_group_l12_norm #(
    .SAMPLE_WIDTH  (SAMPLE_W_DEF),
    .GROUP_LEN_LOG2(GROUP_LEN_LOG2_DEF)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  wgn_norm_checker norm_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .mismatch_count(mismatch_count),
    .open_results  (open_results)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  task automatic offer_coefficient(input logic signed [SAMPLE_W_DEF-1:0] re,
                                   input logic signed [SAMPLE_W_DEF-1:0] im,
                                   input logic [WEIGHT_W-1:0] w,
                                   input logic ge,
                                   input logic se);
    int gap;
    gap = burst_phase ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.re_part   <= re;
    in_ch.im_part   <= im;
    in_ch.weight    <= w;
    in_ch.group_end <= ge;
    in_ch.set_end   <= se;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  function automatic logic [SAMPLE_W_DEF-1:0] draw_sample();
    int near_zero;
    near_zero = int'($urandom_range(0, 8)) - 4;
    case ($urandom_range(0, 7))
      0: return S_MIN;
      1: return S_MAX;
      2: return '0;
      3: return near_zero[SAMPLE_W_DEF-1:0];
      default: return SAMPLE_W_DEF'($urandom);
    endcase
  endfunction

  function automatic logic [WEIGHT_W-1:0] draw_weight();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return WEIGHT_W'(1 << WEIGHT_FRAC);
      default: return WEIGHT_W'($urandom);
    endcase
  endfunction

  task automatic offer_random_group();
    int len;
    bit real_data;
    if ($urandom_range(0, 9) == 0) begin
      // A stray coefficient that may carry set_end without closing its group.
      offer_coefficient(draw_sample(), draw_sample(), draw_weight(), 1'b0,
                        1'($urandom_range(0, 1)));
      return;
    end
    len       = $urandom_range(1, 8);
    real_data = ($urandom_range(0, 3) == 0);
    for (int k = 1; k <= len; k++) begin
      offer_coefficient(draw_sample(), real_data ? '0 : draw_sample(), draw_weight(),
                        k == len,
                        (k == len) ? ($urandom_range(0, 3) == 0) : 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic run_random_groups(input int unsigned count);
    int unsigned start;
    start = items_sent;
    while (items_sent - start < count) offer_random_group();
  endtask

  task automatic wait_for_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (open_results != 0) @(posedge clk);
  endtask

  initial begin
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.re_part   <= '0;
    in_ch.im_part   <= '0;
    in_ch.weight    <= '0;
    in_ch.group_end <= 1'b0;
    in_ch.set_end   <= 1'b0;
    burst_phase = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    offer_coefficient('0, '0, '1, 1'b1, 1'b0);
    offer_coefficient(S_MIN, S_MIN, '1, 1'b1, 1'b0);
    offer_coefficient(S_MAX, '0, WEIGHT_W'(1 << WEIGHT_FRAC), 1'b1, 1'b0);
    offer_coefficient('0, S_MAX, WEIGHT_W'(1), 1'b1, 1'b0);
    offer_coefficient(S_MIN, S_MAX, '0, 1'b1, 1'b0);
    offer_coefficient(-1, 1, '1, 1'b0, 1'b0);
    offer_coefficient(3, -4, WEIGHT_W'(1 << WEIGHT_FRAC), 1'b1, 1'b1);
    offer_coefficient(5, 5, '0, 1'b0, 1'b1);
    offer_coefficient('0, '0, WEIGHT_W'(1 << WEIGHT_FRAC), 1'b1, 1'b0);
    offer_coefficient(S_MAX, S_MAX, WEIGHT_W'(16'h0080), 1'b0, 1'b0);
    offer_coefficient(S_MIN, '0, WEIGHT_W'(16'h8000), 1'b0, 1'b0);
    offer_coefficient(1, -1, WEIGHT_W'(16'h7FFF), 1'b1, 1'b1);

    // A long group of extreme samples sent without gaps.
    burst_phase = 1'b1;
    repeat (LONG_GROUP_LEN - 1) offer_coefficient(S_MIN, S_MIN, '0, 1'b0, 1'b0);
    offer_coefficient(S_MIN, S_MIN, '1, 1'b1, 1'b1);
    burst_phase = 1'b0;
    offer_coefficient('0, '0, '1, 1'b1, 1'b1);

    run_random_groups(130);
    wait_for_results();
    burst_phase = 1'b1;
    run_random_groups(70);
    burst_phase = 1'b0;
    run_random_groups(130);
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && open_results == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    int gap;
    out_ch.ready <= 1'b0;
    long_hold_done = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      gap = burst_phase ? 0 : $urandom_range(0, 4);
      if (results_taken == HOLD_AT && !long_hold_done) begin
        gap            = LONG_HOLD;
        long_hold_done = 1'b1;
      end
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      results_taken++;
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

endmodule
